@@ hdl/gold_sequence_generator_defines.svh @@
// Assertion macros used by the gold sequence generator controller.
`ifndef GOLD_SEQUENCE_GENERATOR_DEFINES_SVH
`define GOLD_SEQUENCE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GSG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GSG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gsg_pkg.sv @@
`timescale 1ns / 1ps

package gsg_pkg;

  localparam int REG_LEN       = 31;
  localparam int SEQ_OFFSET    = 1600;
  localparam int LOAD_STEPS    = SEQ_OFFSET - REG_LEN;
  localparam int OUT_W         = 64;
  localparam int SEED_W        = 31;
  localparam int COUNT_W       = 7;
  localparam int WORD_BITS_DEF = 64;

  localparam logic [REG_LEN-1:0] A_PRESET = 31'h54D21B24;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EMIT,
    S_FINISH
  } gsg_state_e;

  typedef struct packed {
    logic start_load;
    logic start_emit;
    logic step_load;
    logic step_emit;
    logic publish;
  } gsg_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_full;
  } gsg_sts_t;

  function automatic logic fb_a(input logic [REG_LEN-1:0] r);
    return r[3] ^ r[0];
  endfunction

  function automatic logic fb_b(input logic [REG_LEN-1:0] r);
    return r[3] ^ r[2] ^ r[1] ^ r[0];
  endfunction

  function automatic logic [REG_LEN-1:0] lfsr_shift(input logic [REG_LEN-1:0] r,
                                                   input logic fb);
    return {fb, r[REG_LEN-1:1]};
  endfunction

endpackage

@@ hdl/gsg_dp.sv @@
`timescale 1ns / 1ps

module gsg_dp import gsg_pkg::*; #(
  parameter int WordBits = WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gsg_cmd_t           cmd_i,
  output gsg_sts_t           sts_o,
  input  logic [SEED_W-1:0]  seed_i,
  input  logic [COUNT_W-1:0] bit_count_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [OUT_W-1:0]   bits_o
);

  localparam int MaxSteps = (LOAD_STEPS > WordBits) ? LOAD_STEPS : WordBits;
  localparam int CntW     = $clog2(MaxSteps + 1);
  localparam int IdxW     = $clog2(WordBits);

  logic [REG_LEN-1:0]  reg_a_q, reg_a_d;
  logic [REG_LEN-1:0]  reg_b_q, reg_b_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [WordBits-1:0] word_q, word_d;
  logic [OUT_W-1:0]    bits_q, bits_d;
  logic                out_valid_q, out_valid_d;
  logic                fa, fb;
  logic [CntW-1:0]     req_cnt;

  assign fa = fb_a(reg_a_q);
  assign fb = fb_b(reg_b_q);

  always_comb begin
    req_cnt = CntW'(bit_count_i);
    if (req_cnt > CntW'(WordBits)) begin
      req_cnt = CntW'(WordBits);
    end
  end

  always_comb begin
    reg_a_d     = reg_a_q;
    reg_b_d     = reg_b_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    word_d      = word_q;
    bits_d      = bits_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.start_load) begin
      reg_a_d = A_PRESET;
      reg_b_d = seed_i;
      cnt_d   = CntW'(LOAD_STEPS);
      word_d  = '0;
    end
    if (cmd_i.start_emit) begin
      cnt_d  = req_cnt;
      idx_d  = '0;
      word_d = '0;
    end
    if (cmd_i.step_load) begin
      reg_b_d = lfsr_shift(reg_b_q, fb);
      cnt_d   = cnt_q - CntW'(1);
    end
    if (cmd_i.step_emit) begin
      reg_a_d       = lfsr_shift(reg_a_q, fa);
      reg_b_d       = lfsr_shift(reg_b_q, fb);
      word_d[idx_q] = fa ^ fb;
      idx_d         = idx_q + IdxW'(1);
      cnt_d         = cnt_q - CntW'(1);
    end
    if (cmd_i.publish) begin
      bits_d      = OUT_W'(word_q);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_a_q     <= A_PRESET;
      reg_b_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      reg_a_q     <= reg_a_d;
      reg_b_q     <= reg_b_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    bits_q <= bits_d;
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.out_full = out_valid_q & out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign bits_o         = bits_q;

endmodule

@@ hdl/gsg_ctrl.sv @@
`timescale 1ns / 1ps
`include "gold_sequence_generator_defines.svh"

module gsg_ctrl import gsg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     command_i,
  input  gsg_sts_t sts_i,
  output gsg_cmd_t cmd_o
);

  gsg_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (command_i == CMD_LOAD) ? S_LOAD : S_EMIT;
        end
      end
      S_LOAD: begin
        if (sts_i.cnt_zero) begin
          state_d = S_FINISH;
        end
      end
      S_EMIT: begin
        if (sts_i.cnt_zero) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts_i.out_full) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.start_load = in_valid_i & (command_i == CMD_LOAD);
        cmd_o.start_emit = in_valid_i & (command_i == CMD_EMIT);
      end
      S_LOAD:   cmd_o.step_load = ~sts_i.cnt_zero;
      S_EMIT:   cmd_o.step_emit = ~sts_i.cnt_zero;
      S_FINISH: cmd_o.publish   = ~sts_i.out_full;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `GSG_ASSERT_IMP(a_start_idle, clk_i, rst_ni, cmd_o.start_load || cmd_o.start_emit, state_q == S_IDLE, "Item started while busy.")
  `GSG_ASSERT_IMP(a_publish_free, clk_i, rst_ni, cmd_o.publish, !sts_i.out_full, "Result published over a pending one.")
  `GSG_ASSERT_NXT(a_load_done, clk_i, rst_ni, state_q == S_LOAD && sts_i.cnt_zero, state_q == S_FINISH, "Load did not finish.")
  `GSG_ASSERT_NXT(a_emit_done, clk_i, rst_ni, state_q == S_EMIT && sts_i.cnt_zero, state_q == S_FINISH, "Emit did not finish.")

endmodule

@@ hdl/gold_sequence_generator.sv @@
`timescale 1ns / 1ps
// A load takes 1569 register steps at one per cycle before its result is
// published; an emit steps both registers once for each bit it emits.
// Throughput: one item at a time, a new item is taken in the cycle after the
// result is handed to the output register, set by the single-step LFSR loop.
// Reset: register A takes its preset, register B clears, no result is pending.
module gold_sequence_generator import gsg_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [SEED_W-1:0]  seed_i,
  input  logic [COUNT_W-1:0] bit_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OUT_W-1:0]   bits_o
);

  gsg_cmd_t cmd;
  gsg_sts_t sts;

  gsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gsg_dp #(
    .WordBits (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seed_i      (seed_i),
    .bit_count_i (bit_count_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .bits_o      (bits_o)
  );

endmodule

@@ sim/gold_sequence_generator_tb.sv @@
`timescale 1ns / 1ps

module gold_sequence_generator_tb;
  import gsg_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int WORD_BITS      = WORD_BITS_DEF;
  localparam int N_DIRECTED     = 22;
  localparam int N_RANDOM_PHASE = 560;
  localparam int STALL_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic               cmd;
    logic [SEED_W-1:0]  seed;
    logic [COUNT_W-1:0] count;
    logic               known;
    logic [OUT_W-1:0]   word;
  } stim_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               command_i   = CMD_EMIT;
  logic [SEED_W-1:0]  seed_i      = '0;
  logic [COUNT_W-1:0] bit_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [OUT_W-1:0]   bits_o;

  logic [REG_LEN-1:0] x1_q;
  logic [REG_LEN-1:0] x2_q;
  logic [OUT_W-1:0]   pending_words[$];
  stim_row_t          directed_rows[N_DIRECTED];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int fail_count   = 0;
  int idle_cycles  = 0;
  int n_loads      = 0;
  int n_emits      = 0;
  int n_zero       = 0;
  int n_saturated  = 0;
  int n_words      = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  gold_sequence_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .seed_i      (seed_i),
    .bit_count_i (bit_count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bits_o      (bits_o)
  );

  // Advances the two shift registers exactly as the generator does and returns the item word.
  function automatic logic [OUT_W-1:0] gold_advance(input logic cmd,
                                                     input logic [SEED_W-1:0] seed,
                                                     input logic [COUNT_W-1:0] count);
    logic [OUT_W-1:0] word;
    logic             fa;
    logic             fb;
    int               n;
    int               k;
    word = '0;
    if (cmd == CMD_LOAD) begin
      x1_q = A_PRESET;
      x2_q = seed;
      for (k = 0; k < LOAD_STEPS; k++) begin
        x2_q = {^x2_q[3:0], x2_q[REG_LEN-1:1]};
      end
    end else begin
      n = (int'(count) > WORD_BITS) ? WORD_BITS : int'(count);
      for (k = 0; k < n; k++) begin
        fa      = x1_q[3] ^ x1_q[0];
        fb      = ^x2_q[3:0];
        word[k] = fa ^ fb;
        x1_q    = {fa, x1_q[REG_LEN-1:1]};
        x2_q    = {fb, x2_q[REG_LEN-1:1]};
      end
    end
    return word;
  endfunction

  task automatic send_item(input stim_row_t row);
    logic [OUT_W-1:0] predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    command_i   = row.cmd;
    seed_i      = row.seed;
    bit_count_i = row.count;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = gold_advance(row.cmd, row.seed, row.count);
    pending_words.push_back(row.known ? row.word : predicted);
    if (row.cmd == CMD_LOAD) begin
      n_loads++;
    end else begin
      n_emits++;
      if (row.count == '0) n_zero++;
      if (int'(row.count) > WORD_BITS) n_saturated++;
    end
    @(negedge clk_i);
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    row.known = 1'b0;
    row.word  = '0;
    row.seed  = SEED_W'($urandom);
    row.count = COUNT_W'($urandom);
    if ($urandom_range(99) < 4) begin
      row.cmd = CMD_LOAD;
      pick    = $urandom_range(9);
      if (pick == 0) row.seed = '0;
      if (pick == 1) row.seed = '1;
    end else begin
      row.cmd = CMD_EMIT;
      pick    = $urandom_range(99);
      if (pick < 5) row.count = '0;
      else if (pick < 15) row.count = COUNT_W'($urandom_range(127, WORD_BITS + 1));
      else if (pick < 25) row.count = COUNT_W'(WORD_BITS);
      else row.count = COUNT_W'($urandom_range(WORD_BITS, 1));
    end
    return row;
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < snk_idle_pct);
  end

  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_words++;
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: item with no expectation, bits %h", $realtime, bits_o);
        end
      end else begin
        want = pending_words.pop_front();
        if (bits_o !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: bits mismatch, expected %h, got %h", $realtime, want, bits_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("No handshake for %0d cycles, %0d items outstanding.",
                 idle_cycles, pending_words.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int i;
    // Emits before any load run on the preset first register alone.
    directed_rows = '{
      '{CMD_EMIT, 31'h0000_0000, 7'd1,   1'b0, 64'h0},
      '{CMD_EMIT, 31'h7FFF_FFFF, 7'd64,  1'b0, 64'h0},
      '{CMD_EMIT, 31'h1234_5678, 7'd0,   1'b1, 64'h0},
      '{CMD_LOAD, 31'h0000_0000, 7'd127, 1'b1, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd64,  1'b0, 64'h0},
      '{CMD_LOAD, 31'h7FFF_FFFF, 7'd0,   1'b1, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd1,   1'b0, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd63,  1'b0, 64'h0},
      '{CMD_EMIT, 31'h7FFF_FFFF, 7'd64,  1'b0, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd65,  1'b0, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd127, 1'b0, 64'h0},
      '{CMD_EMIT, 31'h7FFF_FFFF, 7'd0,   1'b1, 64'h0},
      '{CMD_LOAD, 31'h0000_0001, 7'd64,  1'b1, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd32,  1'b0, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd31,  1'b0, 64'h0},
      '{CMD_LOAD, 31'h2AAA_AAAA, 7'd1,   1'b1, 64'h0},
      '{CMD_LOAD, 31'h5555_5555, 7'd1,   1'b1, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd64,  1'b0, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd100, 1'b0, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd2,   1'b0, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd8,   1'b0, 64'h0},
      '{CMD_EMIT, 31'h0000_0000, 7'd16,  1'b0, 64'h0}
    };
    x1_q = A_PRESET;
    x2_q = '0;
    src_idle_pct = 18;
    snk_idle_pct = 74;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (i = 0; i < N_DIRECTED; i++) begin
      send_item(directed_rows[i]);
    end

    for (phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 74 : 0;
      snk_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 18 : 0;
      for (i = 0; i < N_RANDOM_PHASE; i++) begin
        send_item(random_row());
      end
    end
    in_valid_i = 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d seed loads and %0d emits (%0d of zero length, %0d saturated).",
             n_loads, n_emits, n_zero, n_saturated);
    $display("Checked %0d output words under three idle patterns, %0d failures.",
             n_words, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
